// ----- rtl/core/pup_pkg.sv -----
`default_nettype none
package pup_pkg;

  localparam int NFIELDS = 11;
  localparam int OUT_W   = 16;
  localparam int POS_W   = 31;
  localparam int ADDR_W  = 16;
  localparam int LEN_W   = 11;

  // input opcodes
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STEP  = 3'd2;
  localparam logic [2:0] OP_COL   = 3'd3;
  localparam logic [2:0] OP_MAX   = 3'd4;

  // CIGAR op codes
  localparam logic [3:0] CIG_M  = 4'd0;
  localparam logic [3:0] CIG_D  = 4'd2;
  localparam logic [3:0] CIG_N  = 4'd3;
  localparam logic [3:0] CIG_EQ = 4'd7;
  localparam logic [3:0] CIG_X  = 4'd8;

  // nt16 base codes
  localparam logic [3:0] NT_A = 4'd1;
  localparam logic [3:0] NT_C = 4'd2;
  localparam logic [3:0] NT_G = 4'd4;
  localparam logic [3:0] NT_T = 4'd8;

  // field slots inside a column word
  localparam int F_TOTAL = 0;
  localparam int F_FWD   = 1;
  localparam int F_REV   = 2;
  localparam int F_FWD_A = 3;
  localparam int F_REV_A = 7;

  typedef enum logic [3:0] {
    CMD_CLEAR = 4'b0001,
    CMD_BUMP  = 4'b0010,
    CMD_READ  = 4'b0100,
    CMD_MAX   = 4'b1000
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic              col_ok;
    logic              strand;
    logic              base_ok;
    logic [1:0]        slot;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
    logic q_full;
  } back_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/pup_front.sv -----
`default_nettype none
module pup_front import pup_pkg::*; #(
  parameter int COLUMNS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [POS_W-1:0]   cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         opcode,
  input  wire logic [POS_W-1:0]   ref_position,
  input  wire logic               reverse_strand,
  input  wire logic               passes_filter,
  input  wire logic [3:0]         cigar_op,
  input  wire logic [3:0]         base,
  input  wire logic [9:0]         column,
  input  wire back_status_t       status,
  output logic                    q_push,
  output cmd_t                    q_data
);

  logic [POS_W-1:0] window_start;
  logic [LEN_W-1:0] window_length;
  logic [POS_W-1:0] cursor;
  logic             strand;
  logic             active;

  logic             accept;
  logic             advance;
  logic [POS_W-1:0] diff;
  logic [31:0]      limit;
  logic [31:0]      diff32;
  logic [31:0]      col32;
  logic             in_window;
  logic             base_ok;
  logic [1:0]       slot;
  logic             need_cmd;

  assign full   = status.q_full | status.init_busy;
  assign accept = push & ~full;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start  <= '0;
      window_length <= LEN_W'(1024);
    end else if (cfg_we) begin
      if (cfg_index) window_length <= cfg_data[LEN_W-1:0];
      else           window_start  <= cfg_data;
    end
  end

  // window test on the cursor
  always_comb begin
    limit     = (32'(window_length) < 32'(COLUMNS)) ? 32'(window_length) : 32'(COLUMNS);
    diff      = cursor - window_start;
    diff32    = 32'(diff);
    in_window = (cursor >= window_start) && (diff32 < limit);
    col32     = 32'(column);
  end

  always_comb begin
    base_ok = 1'b1;
    case (base)
      NT_A:    slot = 2'd0;
      NT_C:    slot = 2'd1;
      NT_G:    slot = 2'd2;
      NT_T:    slot = 2'd3;
      default: begin
        slot    = 2'd0;
        base_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cigar_op)
      CIG_M, CIG_D, CIG_N, CIG_EQ, CIG_X: advance = active;
      default:                           advance = 1'b0;
    endcase
  end

  // classify the beat into a back-end command
  always_comb begin
    q_data         = '0;
    q_data.strand  = strand;
    q_data.base_ok = base_ok;
    q_data.slot    = slot;
    q_data.kind    = CMD_MAX;
    need_cmd       = 1'b0;
    unique case (opcode)
      OP_CLEAR: begin
        q_data.kind = CMD_CLEAR;
        need_cmd    = 1'b1;
      end
      OP_STEP: begin
        q_data.kind = CMD_BUMP;
        q_data.addr = diff32[ADDR_W-1:0];
        need_cmd    = active && (cigar_op == CIG_M) && in_window;
      end
      OP_COL: begin
        q_data.kind   = CMD_READ;
        q_data.addr   = col32[ADDR_W-1:0];
        q_data.col_ok = col32 < 32'(COLUMNS);
        need_cmd      = 1'b1;
      end
      OP_MAX: begin
        q_data.kind = CMD_MAX;
        need_cmd    = 1'b1;
      end
      default: need_cmd = 1'b0;
    endcase
  end

  assign q_push = accept & need_cmd;

  // read state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      strand <= 1'b0;
      active <= 1'b0;
    end else if (accept) begin
      if (opcode == OP_START) begin
        cursor <= ref_position;
        strand <= reverse_strand;
        active <= passes_filter;
      end else if (opcode == OP_STEP && advance) begin
        cursor <= cursor + POS_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pup_cmdq.sv -----
`default_nettype none
module pup_cmdq import pup_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic rd,
  output logic      empty,
  output cmd_t      rdata
);

  localparam int DEPTH = 4;

  cmd_t       slots [DEPTH];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  assign full  = count == 3'(DEPTH);
  assign empty = count == 3'd0;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wdata;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 2'd1;
      if (rd) rptr <= rptr + 2'd1;
      count <= count + 3'(wr) - 3'(rd);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pup_back.sv -----
`default_nettype none
module pup_back import pup_pkg::*; #(
  parameter int COLUMNS    = 1024,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  wire cmd_t                          q_head,
  output logic                               q_pop,
  output logic                               init_busy,
  output logic                               res_valid,
  output logic [NFIELDS-1:0][OUT_W-1:0]      res_data,
  input  wire logic                          res_pop
);

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int WW = NFIELDS * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [CW-1:0] LAST = CW'(COLUMNS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CLR  = 4'b0010,
    S_RD   = 4'b0100,
    S_WR   = 4'b1000
  } state_t;

  state_t                               state;
  state_t                               state_next;
  cmd_t                                 cur;
  logic [CW-1:0]                        clr_addr;
  logic [WW-1:0]                        mem [COLUMNS];
  logic [WW-1:0]                        rdata;
  logic [WW-1:0]                        wdata;
  logic [NFIELDS-1:0]                   sel;
  logic [NFIELDS-1:0][COUNT_BITS-1:0]   maxima;
  logic [NFIELDS-1:0][COUNT_BITS-1:0]   nval;
  logic                                 load_out;
  logic [NFIELDS-1:0][OUT_W-1:0]        load_data;
  logic [31:0]                          tmp;
  logic [CW-1:0]                        addr;

  assign addr = cur.addr[CW-1:0];

  // next state and queue pop
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          case (q_head.kind)
            CMD_CLEAR: begin
              q_pop      = 1'b1;
              state_next = S_CLR;
            end
            CMD_BUMP: begin
              q_pop      = 1'b1;
              state_next = S_RD;
            end
            CMD_READ: begin
              q_pop      = !res_valid;
              state_next = res_valid ? S_IDLE : S_RD;
            end
            default: q_pop = !res_valid;
          endcase
        end
      end
      S_CLR:   if (clr_addr == LAST) state_next = S_IDLE;
      S_RD:    state_next = S_WR;
      S_WR:    state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      init_busy <= 1'b1;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_addr <= (clr_addr == LAST) ? '0 : clr_addr + CW'(1);
        if (clr_addr == LAST) init_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
  end

  // counter update for a bump
  always_comb begin
    for (int j = 0; j < NFIELDS; j++) begin
      sel[j] = (j == F_TOTAL)
            || (j == (cur.strand ? F_REV : F_FWD))
            || (cur.base_ok && j == (cur.strand ? F_REV_A : F_FWD_A) + int'(cur.slot));
      nval[j] = rdata[j*COUNT_BITS +: COUNT_BITS];
      if (sel[j] && nval[j] != CMAX) nval[j] = nval[j] + COUNT_BITS'(1);
      wdata[j*COUNT_BITS +: COUNT_BITS] = nval[j];
    end
  end

  // column store
  always_ff @(posedge clk) begin
    if (state == S_CLR) mem[clr_addr] <= '0;
    else if (state == S_WR && cur.kind == CMD_BUMP) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  // running maxima
  always_ff @(posedge clk) begin
    if (rst || (state == S_IDLE && q_pop && q_head.kind == CMD_CLEAR)) begin
      maxima <= '0;
    end else if (state == S_WR && cur.kind == CMD_BUMP) begin
      for (int j = 0; j < NFIELDS; j++)
        if (sel[j] && nval[j] > maxima[j]) maxima[j] <= nval[j];
    end
  end

  // result source
  always_comb begin
    load_out  = 1'b0;
    load_data = '0;
    tmp       = '0;
    if (state == S_WR && cur.kind == CMD_READ) begin
      load_out = 1'b1;
      for (int j = 0; j < NFIELDS; j++) begin
        tmp          = 32'(rdata[j*COUNT_BITS +: COUNT_BITS]);
        load_data[j] = cur.col_ok ? tmp[OUT_W-1:0] : '0;
      end
    end else if (state == S_IDLE && q_pop && q_head.kind == CMD_MAX) begin
      load_out = 1'b1;
      for (int j = 0; j < NFIELDS; j++) begin
        tmp          = 32'(maxima[j]);
        load_data[j] = tmp[OUT_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (load_out) res_valid <= 1'b1;
    else if (res_pop) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) res_data <= load_data;
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) q_pop |-> state == S_IDLE)
    else $error("queue popped while busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst) load_out |-> !res_valid)
    else $error("result overwritten");
  a_clr_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR && clr_addr == LAST) |=> state == S_IDLE)
    else $error("clear sweep did not end");

endmodule
`default_nettype wire

// ----- rtl/core/read_pileup_base_counter.sv -----
// Channel  Handshake            Moves
// input    push / full          opcode, ref_position, strand, filter, cigar_op, base, column
// result   pop / empty          eleven 16-bit counters of a column or their maxima
// config   cfg_we               cfg_index selects window_start (0) or window_length (1)
//
// Read start, non-counting steps and opcodes 5..7 are handled in the front end alone.
// A counted step or column read passes the back end in order (queue pop, column
// store read, then update and write or result load); maxima readout loads at the pop.
// The store has one write port and one read port. Reset sweeps the store, full is high
// meanwhile; a clear occupies the back end for the pop, then the sweep.
// A 4-deep command queue lets the front keep taking beats while the back works.
// A waiting result stalls the next column or maxima readout until it is popped.
`default_nettype none
module read_pileup_base_counter import pup_pkg::*; #(
  parameter int COLUMNS    = 1024,
  parameter int COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [POS_W-1:0]   cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         opcode,
  input  wire logic [POS_W-1:0]   ref_position,
  input  wire logic               reverse_strand,
  input  wire logic               passes_filter,
  input  wire logic [3:0]         cigar_op,
  input  wire logic [3:0]         base,
  input  wire logic [9:0]         column,
  output logic                    empty,
  input  wire logic               pop,
  output logic [OUT_W-1:0]        total_count,
  output logic [OUT_W-1:0]        forward_count,
  output logic [OUT_W-1:0]        reverse_count,
  output logic [OUT_W-1:0]        forward_a,
  output logic [OUT_W-1:0]        forward_c,
  output logic [OUT_W-1:0]        forward_g,
  output logic [OUT_W-1:0]        forward_t,
  output logic [OUT_W-1:0]        reverse_a,
  output logic [OUT_W-1:0]        reverse_c,
  output logic [OUT_W-1:0]        reverse_g,
  output logic [OUT_W-1:0]        reverse_t
);

  back_status_t                  status;
  logic                          q_push;
  cmd_t                          q_wdata;
  logic                          q_full;
  logic                          q_pop;
  logic                          q_empty;
  cmd_t                          q_head;
  logic                          init_busy;
  logic                          res_valid;
  logic [NFIELDS-1:0][OUT_W-1:0] res_data;

  assign status.q_full    = q_full;
  assign status.init_busy = init_busy;

  pup_front #(.COLUMNS(COLUMNS)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .push, .full, .opcode, .ref_position,
    .reverse_strand, .passes_filter, .cigar_op, .base, .column, .status,
    .q_push, .q_data(q_wdata)
  );

  pup_cmdq u_q (
    .clk, .rst, .wr(q_push), .wdata(q_wdata), .full(q_full),
    .rd(q_pop), .empty(q_empty), .rdata(q_head)
  );

  pup_back #(.COLUMNS(COLUMNS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst, .q_empty, .q_head, .q_pop, .init_busy,
    .res_valid, .res_data, .res_pop(pop & res_valid)
  );

  assign empty         = ~res_valid;
  assign total_count   = res_data[0];
  assign forward_count = res_data[1];
  assign reverse_count = res_data[2];
  assign forward_a     = res_data[3];
  assign forward_c     = res_data[4];
  assign forward_g     = res_data[5];
  assign forward_t     = res_data[6];
  assign reverse_a     = res_data[7];
  assign reverse_c     = res_data[8];
  assign reverse_g     = res_data[9];
  assign reverse_t     = res_data[10];

endmodule
`default_nettype wire

// ----- sim/read_pileup_base_counter_tb.sv -----
`default_nettype none
module read_pileup_base_counter_tb import pup_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS  = 1024;
  localparam int CNT_MAX  = 65535;
  localparam int LIMIT    = 3000000;
  localparam int SETTLE   = 1300;   // clear sweep plus queued back-end work
  localparam logic REG_WINDOW_START  = 1'b0;
  localparam logic REG_WINDOW_LENGTH = 1'b1;
  localparam logic [3:0] CIG_I = 4'd1;
  localparam logic [3:0] CIG_S = 4'd4;
  localparam logic [3:0] CIG_H = 4'd5;
  localparam logic [3:0] CIG_P = 4'd6;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;

  typedef struct {
    logic [2:0]       opcode;
    logic [POS_W-1:0] pos;
    logic             rev;
    logic             pass;
    logic [3:0]       cop;
    logic [3:0]       base;
    logic [9:0]       col;
  } beat_t;

  typedef logic [NFIELDS-1:0][OUT_W-1:0] counters_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0, cfg_index = 0;
  logic [POS_W-1:0] cfg_data = '0;
  logic push = 0, pop = 0;
  logic [2:0] opcode = '0;
  logic [POS_W-1:0] ref_position = '0;
  logic reverse_strand = 0, passes_filter = 0;
  logic [3:0] cigar_op = '0, base = '0;
  logic [9:0] column = '0;
  logic full, empty;
  logic [OUT_W-1:0] total_count, forward_count, reverse_count;
  logic [OUT_W-1:0] forward_a, forward_c, forward_g, forward_t;
  logic [OUT_W-1:0] reverse_a, reverse_c, reverse_g, reverse_t;

  read_pileup_base_counter u_dut (.*);

  // pileup model state
  int unsigned col_counts[COLUMNS][NFIELDS];
  int unsigned peak[NFIELDS];
  logic [POS_W-1:0] cursor, win_start;
  logic [LEN_W-1:0] win_len;
  logic strand, active;
  counters_t pileup_q[$];

  int unsigned cycles, mismatches, beats_sent, results_seen;
  int send_idle_pct, recv_stall_pct, hold_cycles;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("read_pileup_base_counter verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs counted here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check against the oldest expected beat
  always @(posedge clk) begin
    counters_t got, want;
    if (!rst && pop && !empty) begin
      got = {reverse_t, reverse_g, reverse_c, reverse_a, forward_t, forward_g,
             forward_c, forward_a, reverse_count, forward_count, total_count};
      results_seen++;
      if (pileup_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pileup_q.pop_front();
        for (int f = 0; f < NFIELDS; f++)
          if (got[f] !== want[f]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %0d got %0d", f, want[f], got[f]);
          end
      end
    end
  end

  function automatic void bump(int c, int f);
    if (col_counts[c][f] < CNT_MAX) col_counts[c][f]++;
    if (col_counts[c][f] > peak[f]) peak[f] = col_counts[c][f];
  endfunction

  function automatic void count_match(logic [3:0] b);
    int unsigned lim, c;
    lim = (win_len < COLUMNS) ? win_len : COLUMNS;
    if (cursor < win_start) return;
    c = cursor - win_start;
    if (c >= lim) return;
    bump(c, F_TOTAL);
    bump(c, strand ? F_REV : F_FWD);
    case (b)
      NT_A: bump(c, (strand ? F_REV_A : F_FWD_A) + 0);
      NT_C: bump(c, (strand ? F_REV_A : F_FWD_A) + 1);
      NT_G: bump(c, (strand ? F_REV_A : F_FWD_A) + 2);
      NT_T: bump(c, (strand ? F_REV_A : F_FWD_A) + 3);
      default: ;
    endcase
  endfunction

  function automatic void pileup_update(beat_t b);
    counters_t r;
    case (b.opcode)
      OP_CLEAR: begin
        foreach (col_counts[i, j]) col_counts[i][j] = 0;
        foreach (peak[j]) peak[j] = 0;
      end
      OP_START: begin
        cursor = b.pos;
        strand = b.rev;
        active = b.pass;
      end
      OP_STEP: if (active) begin
        case (b.cop)
          CIG_M: begin
            count_match(b.base);
            cursor = cursor + 1'b1;
          end
          CIG_D, CIG_N, CIG_EQ, CIG_X: cursor = cursor + 1'b1;
          default: ;
        endcase
      end
      OP_COL: begin
        for (int f = 0; f < NFIELDS; f++) r[f] = col_counts[b.col][f][OUT_W-1:0];
        pileup_q = {pileup_q, r};
      end
      OP_MAX: begin
        for (int f = 0; f < NFIELDS; f++) r[f] = peak[f][OUT_W-1:0];
        pileup_q = {pileup_q, r};
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    opcode <= b.opcode; ref_position <= b.pos; reverse_strand <= b.rev;
    passes_filter <= b.pass; cigar_op <= b.cop; base <= b.base; column <= b.col;
    do @(posedge clk); while (full);
    pileup_update(b);
    beats_sent++;
  endtask

  task automatic send_op(logic [2:0] op, logic [POS_W-1:0] pos = '0, logic rev = 0,
                         logic pass = 1, logic [3:0] cop = CIG_M,
                         logic [3:0] b = NT_A, logic [9:0] col = '0);
    beat_t t;
    t = '{op, pos, rev, pass, cop, b, col};
    send_beat(t);
  endtask

  // idle the input, wait for every result, let the back end settle
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pileup_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [POS_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_START) win_start = data;
    else win_len = data[LEN_W-1:0];
  endtask

  task automatic set_window(logic [POS_W-1:0] ws, logic [POS_W-1:0] wl);
    drain();
    write_reg(REG_WINDOW_START, ws);
    write_reg(REG_WINDOW_LENGTH, wl);
  endtask

  // field extremes, every opcode and cigar op, filter and no-read cases
  task automatic test_directed();
    set_window(0, 1024);
    send_op(OP_MAX);
    send_op(OP_START, 0, 0, 1);
    send_op(OP_STEP, , , , CIG_M, NT_A);
    send_op(OP_STEP, , , , CIG_M, NT_C);
    send_op(OP_STEP, , , , CIG_I, NT_G);
    send_op(OP_STEP, , , , CIG_S, NT_G);
    send_op(OP_STEP, , , , CIG_H);
    send_op(OP_STEP, , , , CIG_P);
    send_op(OP_STEP, , , , CIG_M, NT_G);
    send_op(OP_STEP, , , , CIG_D);
    send_op(OP_STEP, , , , CIG_N);
    send_op(OP_STEP, , , , CIG_EQ);
    send_op(OP_STEP, , , , CIG_X);
    send_op(OP_STEP, , , , 4'd9);
    send_op(OP_STEP, , , , 4'd15, 4'd15);
    send_op(OP_STEP, , , , CIG_M, NT_T);
    send_op(OP_STEP, , , , CIG_M, 4'd0);
    send_op(OP_START, 1023, 1, 1);
    send_op(OP_STEP, , , , CIG_M, 4'd15);
    send_op(OP_START, 2, 1, 0);
    send_op(OP_STEP, , , , CIG_M, NT_A);
    for (int k = 0; k < 3; k++) send_op(OP_RSVD_LO + 3'(k), '1, 1, 1, 4'hF, 4'hF, '1);
    send_op(OP_COL, , , , , , 0);
    send_op(OP_COL, , , , , , 1);
    send_op(OP_COL, , , , , , 1023);
    send_op(OP_MAX);
    send_op(OP_CLEAR);
    send_op(OP_COL, , , , , , 0);
    send_op(OP_MAX);
  endtask

  // mostly well-formed reads around the window, some noise
  task automatic random_traffic(int n);
    int done, lim, steps;
    beat_t t;
    done = 0;
    lim = (win_len < COLUMNS) ? win_len : COLUMNS;
    while (done < n) begin
      case ($urandom_range(99)) inside
        [0:69]: begin
          send_op(OP_START, POS_W'(win_start + $urandom_range(lim + 8) - 8),
                  1'($urandom_range(1)), $urandom_range(9) != 0);
          steps = $urandom_range(1, 30);
          for (int s = 0; s < steps; s++)
            send_op(OP_STEP, POS_W'($urandom), 1'($urandom_range(1)),
                    1'($urandom_range(1)),
                    ($urandom_range(9) < 6) ? CIG_M : 4'($urandom_range(15)),
                    ($urandom_range(9) < 8) ? 4'(1 << $urandom_range(3))
                                            : 4'($urandom_range(15)), 10'($urandom));
          done += steps + 1;
        end
        [70:84]: begin
          send_op(OP_COL, POS_W'($urandom), , , , ,
                  ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(lim + 2)));
          done++;
        end
        [85:92]: begin send_op(OP_MAX); done++; end
        93: begin send_op(OP_CLEAR); done++; end
        default: begin
          t = '{3'($urandom), POS_W'($urandom), 1'($urandom), 1'($urandom),
                4'($urandom), 4'($urandom), 10'($urandom)};
          send_beat(t);
          done++;
        end
      endcase
    end
  endtask

  task automatic test_random();
    int idle[4] = '{0, 49, 0, 15};
    int stall[4] = '{0, 0, 49, 15};
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_window(0, 64);
        1: set_window(31'h7FFF_FFF0, 2047);
        2: set_window(POS_W'($urandom), 1);
        default: set_window(100, 40);
      endcase
      send_idle_pct = idle[p];
      recv_stall_pct = stall[p];
      random_traffic(420);
    end
    set_window(200, 0);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_traffic(40);
  endtask

  // long receiver hold-off fills the block; then a full drain
  task automatic test_backpressure();
    set_window(0, 16);
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_cycles = 400;
    for (int k = 0; k < 30; k++) begin
      send_op(OP_START, POS_W'(k % 8), k[0], 1);
      send_op(OP_STEP, , , , CIG_M, 4'(1 << (k % 4)));
      send_op(OP_COL, , , , , , 10'(k % 16));
    end
    drain();
    send_op(OP_MAX);
  endtask

  initial begin
    win_start = '0; win_len = 1024; cursor = '0; strand = 0; active = 0;
    foreach (col_counts[i, j]) col_counts[i][j] = 0;
    foreach (peak[j]) peak[j] = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    drain();
    $display("Covered %0d input beats and %0d result beats: directed ops, backpressure,",
             beats_sent, results_seen);
    $display("random reads over several windows and idle mixes.");
    if (mismatches == 0 && pileup_q.size() == 0)
      $display("read_pileup_base_counter verification clean");
    else
      $display("read_pileup_base_counter verification failed");
    $finish;
  end

endmodule
`default_nettype wire
